FILE: rtl/core/ogru_pkg.sv
// Shared types and constants for the occupancy grid ray update block.
package ogru_pkg;

	// Width of the configuration register index.
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_INV_RES   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POSE_X    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POSE_Y    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEADING   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_INC = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ODDS_OCC  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ODDS_EMP  = 3'd7;

	// Request opcodes.
	localparam logic OPC_BEAM = 1'b0;
	localparam logic OPC_READ = 1'b1;

	// Sine polynomial coefficients and unity, all Q14.
	localparam logic [14:0] SIN_A    = 15'd25736;
	localparam logic [14:0] SIN_B    = 15'd10512;
	localparam logic [14:0] SIN_C    = 15'd1160;
	localparam logic [14:0] Q14_ONE  = 15'd16384;
	localparam logic [15:0] QUARTER  = 16'd16384;

	// Occupancy percentages.
	localparam logic [6:0] P_MAX      = 7'd100;
	localparam logic [6:0] CELL_RESET = 7'd1;

	// Width of the signed Q14 cell position accumulators.
	localparam int POS_W = 29;

	// Main sequencer states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_SIN,
		ST_COS,
		ST_CELL_ADDR,
		ST_CELL_DATA,
		ST_CELL_CALC,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/core/ogru_req_if.sv
// Request channel: beam or cell read items.
interface ogru_req_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [15:0] beam_range;
	logic       last_beam;
	logic [7:0] cell_x;
	logic [7:0] cell_y;

	modport source (output valid, opcode, beam_range, last_beam, cell_x, cell_y, input ready);
	modport sink (input valid, opcode, beam_range, last_beam, cell_x, cell_y, output ready);
endinterface

FILE: rtl/core/ogru_rsp_if.sv
// Response channel: one result per request.
interface ogru_rsp_if;
	logic       valid;
	logic       ready;
	logic [9:0] cells_updated;
	logic [6:0] cell_value;

	modport source (output valid, cells_updated, cell_value, input ready);
	modport sink (input valid, cells_updated, cell_value, output ready);
endinterface

FILE: rtl/core/ogru_cfg_if.sv
// Configuration write channel.
interface ogru_cfg_if import ogru_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [15:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/ogru_ram.sv
// Generic synchronous RAM with one write port and one registered read port.
module ogru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/ogru_trig.sv
// Iterative Q14 sine unit: one shared multiplier, four products per result.
module ogru_trig import ogru_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [15:0]        angle,
	output logic               done,
	output logic signed [15:0] value
);

	logic        busy_q;
	logic [1:0]  cnt_q;
	logic        done_q;
	logic [14:0] z_q;
	logic [14:0] z2_q;
	logic [14:0] t_q;
	logic        neg_q;
	logic signed [15:0] val_q;
	logic [14:0] z_in;
	logic [14:0] z_fold;
	logic [14:0] op_a;
	logic [14:0] op_b;
	logic [29:0] prod;
	logic [14:0] prod_sh;

	// Fold the angle onto the first quarter wave.
	always_comb begin
		z_in   = {1'b0, angle[13:0]};
		z_fold = angle[14] ? (Q14_ONE - z_in) : z_in;
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		case (cnt_q)
			2'd0: begin
				op_a = z_q;
				op_b = z_q;
			end
			2'd1: begin
				op_a = SIN_C;
				op_b = z2_q;
			end
			2'd2: begin
				op_a = t_q;
				op_b = z2_q;
			end
			default: begin
				op_a = t_q;
				op_b = z_q;
			end
		endcase
		prod    = {15'd0, op_a} * {15'd0, op_b};
		prod_sh = prod[28:14];
	end

	// Sequencing control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == 2'd3);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Polynomial datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			z_q   <= z_fold;
			neg_q <= angle[15];
		end else if (busy_q) begin
			case (cnt_q)
				2'd0: z2_q <= prod_sh;
				2'd1: t_q <= SIN_B - prod_sh;
				2'd2: t_q <= SIN_A - prod_sh;
				default: val_q <= neg_q ? -$signed({1'b0, prod_sh}) : $signed({1'b0, prod_sh});
			endcase
		end
	end

	assign done  = done_q;
	assign value = val_q;

endmodule

FILE: rtl/core/ogru_bayes.sv
// Bayesian odds update of one cell with a restoring divider, one quotient bit a cycle.
module ogru_bayes import ogru_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [6:0]  p,
	input  logic [15:0] d,
	output logic        done,
	output logic [6:0]  q
);

	logic        busy_q;
	logic [2:0]  ph_q;
	logic        done_q;
	logic [22:0] dp_q;
	logic [6:0]  p_q;
	logic [29:0] rem_q;
	logic [28:0] dsh_q;
	logic [6:0]  quo_q;
	logic        nz_q;
	logic [29:0] num;
	logic [22:0] den;
	logic [6:0]  p_diff;
	logic        fits;

	// Numerator and denominator from the registered odds product.
	always_comb begin
		p_diff = P_MAX - p_q;
		num    = 30'(dp_q) * 30'(P_MAX);
		den    = {4'd0, p_diff, 12'd0} + dp_q;
		fits   = rem_q >= {1'b0, dsh_q};
	end

	// Sequencing control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (ph_q == 3'd7);
			if (start) begin
				busy_q <= 1'b1;
				ph_q   <= 3'd0;
			end else if (busy_q) begin
				ph_q <= ph_q + 3'd1;
				if (ph_q == 3'd7) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Product, set-up and division steps.
	always_ff @(posedge clk) begin
		if (start) begin
			dp_q <= {7'd0, d} * {16'd0, p};
			p_q  <= p;
		end else if (busy_q) begin
			if (ph_q == 3'd0) begin
				rem_q <= num;
				dsh_q <= {den, 6'd0};
				nz_q  <= den != 23'd0;
				quo_q <= 7'd0;
			end else begin
				if (fits) begin
					rem_q <= rem_q - {1'b0, dsh_q};
				end
				quo_q <= {quo_q[5:0], fits};
				dsh_q <= dsh_q >> 1;
			end
		end
	end

	// A zero denominator yields an empty cell; a quotient above P_MAX is clamped to P_MAX.
	always_comb begin
		if (!nz_q) begin
			q = 7'd0;
		end else if (quo_q > P_MAX) begin
			q = P_MAX;
		end else begin
			q = quo_q;
		end
	end

	assign done = done_q;

endmodule

FILE: rtl/core/occupancy_grid_ray_update.sv
// Top level of the occupancy grid ray update block.
//
// Requests arrive on req: a beam (opcode 0) casts a ray from the sensor pose and
// updates every cell it walks through, a read (opcode 1) returns one grid cell.
// Every request gives one response on rsp: cells_updated for a beam, cell_value
// for a read. Configuration writes on cfg are always taken at once.
// One request is handled at a time. A read passes through RD_ADDR, RD_DATA and
// DONE; a new request can be taken in the same cycle as its response appears.
// A beam computes the sine in SIN and the cosine in COS, walks steps+1 cells,
// then hands over the response in DONE. Each cell is a grid read in CELL_ADDR,
// the wait for the read data in CELL_DATA and the odds update in CELL_CALC,
// whose restoring divider produces one quotient bit a cycle.
// The response sits in an output register, so a stalled receiver only holds the
// next response in DONE until the register is free.
// After reset the grid is cleared to 1 one cell a cycle, all
// (2**clog2(GRID_SIZE))**2 cells, 65536 with the default size; req.ready stays
// low until the clear is done.
module occupancy_grid_ray_update import ogru_pkg::*; #(
	parameter int GRID_SIZE = 256,
	parameter int MAX_STEPS = 511
) (
	input  logic       clk,
	input  logic       arst_n,
	ogru_req_if.sink   req,
	ogru_rsp_if.source rsp,
	ogru_cfg_if.sink   cfg
);

	localparam int CW = $clog2(GRID_SIZE);
	localparam int AW = 2 * CW;
	localparam int SW = $clog2(MAX_STEPS + 1);

	state_t state_q, state_d;

	logic [15:0] inv_res_q, heading_q, amin_q, ainc_q, odds_occ_q, odds_emp_q;
	logic [7:0]  pose_x_q, pose_y_q;
	logic [15:0] offset_q;
	logic        out_valid_q;
	logic [9:0]  out_cnt_q;
	logic [6:0]  out_val_q;
	logic [AW-1:0] clr_q;

	logic        last_q;
	logic [31:0] prod_q;
	logic [15:0] ang_q;
	logic [AW-1:0] addr_q;
	logic        inmap_q;
	logic [SW-1:0] steps_q, dist_q;
	logic signed [15:0] sn_q, cs_q;
	logic signed [POS_W-1:0] sx_q, sy_q;
	logic [9:0]  res_cnt_q;
	logic [6:0]  res_val_q;

	logic        accept;
	logic [15:0] angle_c;
	logic [SW-1:0] steps_c;
	logic [SW:0] cnt_c;
	logic [CW-1:0] xcl, ycl;
	logic [AW-1:0] cell_addr_c;
	logic        last_cell;

	logic        trig_start, trig_done;
	logic [15:0] trig_ang;
	logic signed [15:0] trig_val;
	logic        bay_start, bay_done;
	logic [6:0]  bay_p, bay_q;
	logic [15:0] bay_d;
	logic        ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [6:0]  ram_wdata, ram_rdata;
	logic        out_load;

	// Shared address, angle and step arithmetic.
	always_comb begin
		accept      = req.valid && req.ready;
		angle_c     = heading_q + amin_q + offset_q;
		steps_c     = (prod_q[31:16] > 16'(MAX_STEPS)) ? SW'(MAX_STEPS) : SW'(prod_q[31:16]);
		cnt_c       = {1'b0, steps_q} + {{SW{1'b0}}, 1'b1};
		last_cell   = dist_q == steps_q;
		cell_addr_c = {ycl, xcl};
	end

	// Clip the accumulated positions to the map.
	always_comb begin
		if (sx_q[POS_W-1]) begin
			xcl = '0;
		end else if (sx_q[POS_W-2:14] >= (POS_W-15)'(GRID_SIZE)) begin
			xcl = CW'(GRID_SIZE - 1);
		end else begin
			xcl = sx_q[CW+13:14];
		end
		if (sy_q[POS_W-1]) begin
			ycl = '0;
		end else if (sy_q[POS_W-2:14] >= (POS_W-15)'(GRID_SIZE)) begin
			ycl = CW'(GRID_SIZE - 1);
		end else begin
			ycl = sy_q[CW+13:14];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == '1) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					state_d = (req.opcode == OPC_READ) ? ST_RD_ADDR : ST_SIN;
				end
			end
			ST_RD_ADDR: state_d = ST_RD_DATA;
			ST_RD_DATA: state_d = ST_DONE;
			ST_SIN: if (trig_done) state_d = ST_COS;
			ST_COS: if (trig_done) state_d = ST_CELL_ADDR;
			ST_CELL_ADDR: state_d = ST_CELL_DATA;
			ST_CELL_DATA: state_d = ST_CELL_CALC;
			ST_CELL_CALC: begin
				if (bay_done) begin
					state_d = last_cell ? ST_DONE : ST_CELL_ADDR;
				end
			end
			ST_DONE: if (!out_valid_q || rsp.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		req.ready  = state_q == ST_IDLE;
		trig_start = (state_q == ST_IDLE && accept && req.opcode == OPC_BEAM)
			|| (state_q == ST_SIN && trig_done);
		trig_ang   = (state_q == ST_IDLE) ? angle_c : ang_q + QUARTER;
		bay_start  = state_q == ST_CELL_DATA;
		bay_p      = (ram_rdata > P_MAX) ? P_MAX : ram_rdata;
		bay_d      = last_cell ? odds_occ_q : odds_emp_q;
		ram_re     = state_q == ST_RD_ADDR || state_q == ST_CELL_ADDR;
		ram_raddr  = (state_q == ST_CELL_ADDR) ? cell_addr_c : addr_q;
		ram_we     = state_q == ST_CLEAR || (state_q == ST_CELL_CALC && bay_done);
		ram_waddr  = (state_q == ST_CLEAR) ? clr_q : addr_q;
		ram_wdata  = (state_q == ST_CLEAR) ? CELL_RESET : bay_q;
		out_load   = state_q == ST_DONE && (!out_valid_q || rsp.ready);
	end

	// Control state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			offset_q    <= '0;
			inv_res_q   <= 16'd2560;
			pose_x_q    <= 8'd128;
			pose_y_q    <= 8'd128;
			heading_q   <= '0;
			amin_q      <= '0;
			ainc_q      <= '0;
			odds_occ_q  <= 16'd8192;
			odds_emp_q  <= 16'd2048;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_CELL_CALC && bay_done && last_cell) begin
				offset_q <= last_q ? 16'd0 : offset_q + ainc_q;
			end
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_INV_RES:   inv_res_q  <= cfg.data;
					REG_POSE_X:    pose_x_q   <= cfg.data[7:0];
					REG_POSE_Y:    pose_y_q   <= cfg.data[7:0];
					REG_HEADING:   heading_q  <= cfg.data;
					REG_ANGLE_MIN: amin_q     <= cfg.data;
					REG_ANGLE_INC: ainc_q     <= cfg.data;
					REG_ODDS_OCC:  odds_occ_q <= cfg.data;
					REG_ODDS_EMP:  odds_emp_q <= cfg.data;
					default: ;
				endcase
			end
		end
	end

	assign cfg.ready = 1'b1;

	// Request datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			last_q  <= req.last_beam;
			prod_q  <= {16'd0, req.beam_range} * {16'd0, inv_res_q};
			ang_q   <= angle_c;
			addr_q  <= {CW'(req.cell_y), CW'(req.cell_x)};
			inmap_q <= ({3'd0, req.cell_x} < 11'(GRID_SIZE))
				&& ({3'd0, req.cell_y} < 11'(GRID_SIZE));
		end
		if (state_q == ST_SIN && trig_done) begin
			sn_q    <= trig_val;
			steps_q <= steps_c;
		end
		if (state_q == ST_COS && trig_done) begin
			cs_q   <= trig_val;
			sx_q   <= $signed({{(POS_W-22){1'b0}}, pose_x_q, 14'd0});
			sy_q   <= $signed({{(POS_W-22){1'b0}}, pose_y_q, 14'd0});
			dist_q <= '0;
		end
		if (state_q == ST_CELL_ADDR) begin
			addr_q <= cell_addr_c;
		end
		if (state_q == ST_CELL_CALC && bay_done) begin
			if (last_cell) begin
				res_cnt_q <= 10'(cnt_c);
				res_val_q <= '0;
			end else begin
				dist_q <= dist_q + SW'(1);
				sx_q   <= sx_q + {{(POS_W-16){sn_q[15]}}, sn_q};
				sy_q   <= sy_q + {{(POS_W-16){cs_q[15]}}, cs_q};
			end
		end
		if (state_q == ST_RD_DATA) begin
			res_cnt_q <= '0;
			res_val_q <= inmap_q ? ram_rdata : 7'd0;
		end
		if (out_load) begin
			out_cnt_q <= res_cnt_q;
			out_val_q <= res_val_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.cells_updated = out_cnt_q;
	assign rsp.cell_value    = out_val_q;

	// Sine and cosine unit.
	ogru_trig u_trig (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (trig_start),
		.angle  (trig_ang),
		.done   (trig_done),
		.value  (trig_val)
	);

	// Odds update unit.
	ogru_bayes u_bayes (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bay_start),
		.p      (bay_p),
		.d      (bay_d),
		.done   (bay_done),
		.q      (bay_q)
	);

	// Occupancy grid store.
	ogru_ram #(
		.WIDTH (7),
		.DEPTH (1 << AW)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

`ifndef ASSERT_OFF
	ap_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !ram_we) else $error("grid written while idle");
	ap_trig_done: assert property (@(posedge clk) disable iff (!arst_n)
		trig_done |-> (state_q == ST_SIN || state_q == ST_COS))
		else $error("sine result outside the angle phase");
	ap_bayes_done: assert property (@(posedge clk) disable iff (!arst_n)
		bay_done |-> state_q == ST_CELL_CALC) else $error("odds result outside a cell update");
	ap_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.cells_updated == 10'd0 || rsp.cell_value == 7'd0))
		else $error("response carries both a count and a value");
	ap_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CELL_DATA |-> dist_q <= steps_q) else $error("ray walked past its end");
`endif

endmodule
